### design/hwdm_pkg.sv
`timescale 1ns / 1ps

package hwdm_pkg;

    // Field widths fixed by the item and register formats.
    localparam int TIME_W = 32;
    localparam int HEALTH_W = 16;
    localparam int CAP_W = 5;
    localparam int THR_W = 20;
    localparam int MWIN_W = 16;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register indexes on the configuration port (byte address is four times this).
    localparam logic [1:0] REG_CAPACITY = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_MATCH_WIN = 2'd2;

    localparam logic [CAP_W-1:0] CAPACITY_RST = 5'd16;
    localparam logic [THR_W-1:0] THRESHOLD_RST = 20'd1;
    localparam logic [MWIN_W-1:0] MATCH_WIN_RST = 16'd100;

    // Operation codes carried on the input tuser.
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_DRAIN = 7'b0000100,
        S_EVICT = 7'b0001000,
        S_STORE = 7'b0010000,
        S_FLAG  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // take the accepted item and clear the scan trackers
        logic scan;      // read the next window entry
        logic evict_wr;  // move the last entry into the slot of the oldest one
        logic store_wr;  // write the new pair and update sum and count
        logic flag_upd;  // update the hysteresis flag from the new sum
        logic result;    // load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic last_addr;
        logic is_query;
        logic out_busy;
    } t_sts;

endpackage

### design/hwdm_ctrl.sv
`timescale 1ns / 1ps

module hwdm_ctrl import hwdm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.empty) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.scan = 1'b1;
                    if (i_sts.last_addr) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                // The last read word is folded into the trackers in this cycle.
                n_state = i_sts.is_query ? S_DONE : S_EVICT;
            end
            S_EVICT: begin
                o_cmd.evict_wr = 1'b1;
                n_state = S_STORE;
            end
            S_STORE: begin
                o_cmd.store_wr = 1'b1;
                n_state = S_FLAG;
            end
            S_FLAG: begin
                o_cmd.flag_upd = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.result = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### design/hwdm_dp.sv
`timescale 1ns / 1ps

module hwdm_dp import hwdm_pkg::*; #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic                i_op,
    input  logic [TIME_W-1:0]   i_ts,
    input  logic [HEALTH_W-1:0] i_hv,
    input  logic [CAP_W-1:0]    i_cap,
    input  logic [THR_W-1:0]    i_thr,
    input  logic [MWIN_W-1:0]   i_mwin,
    input  logic                i_m_tready,
    output logic                o_m_tvalid,
    output logic                o_healthy,
    output logic                o_matched,
    output logic                o_degenerate,
    output logic                o_was_degenerate
);

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = HEALTH_W + CNT_W;
    localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;
    localparam int WORD_W = TIME_W + HEALTH_W;

    // Window entries are kept unordered: each slot holds {time, health}.
    logic [WORD_W-1:0] r_mem [WINDOW_DEPTH];

    logic                r_op;
    logic [TIME_W-1:0]   r_ts;
    logic [HEALTH_W-1:0] r_hv;
    logic [AW-1:0]       r_addr;
    logic [WORD_W-1:0]   r_rd_word;
    logic [AW-1:0]       r_rd_idx;
    logic                r_rd_vld;
    logic                r_have;
    logic [TIME_W-1:0]   r_min_t;
    logic [AW-1:0]       r_min_idx;
    logic [HEALTH_W-1:0] r_min_h;
    logic [TIME_W-1:0]   r_best_d;
    logic [TIME_W-1:0]   r_best_t;
    logic [HEALTH_W-1:0] r_best_h;
    logic                r_eq_found;
    logic [AW-1:0]       r_eq_idx;
    logic [HEALTH_W-1:0] r_eq_h;
    logic [WORD_W-1:0]   r_last_word;
    logic [CNT_W-1:0]    r_count;
    logic [SUM_W-1:0]    r_sum;
    logic                r_flag;
    logic                r_prev_flag;
    logic                r_out_valid;
    logic                r_out_healthy;
    logic                r_out_matched;
    logic                r_out_degenerate;
    logic                r_out_was_degenerate;

    logic [TIME_W-1:0]   w_t;
    logic [HEALTH_W-1:0] w_h;
    logic [TIME_W-1:0]   w_d;
    logic [CNT_W-1:0]    w_last_cnt;
    logic [AW-1:0]       w_last_idx;
    logic                w_evict;
    logic                w_eq_gone;
    logic                w_eqf;
    logic [AW-1:0]       w_eq_pos;
    logic [AW-1:0]       w_new_pos;
    logic                w_wr_en;
    logic [AW-1:0]       w_wr_addr;
    logic [WORD_W-1:0]   w_wr_data;
    logic                w_matched;

    assign w_t = r_rd_word[WORD_W-1:HEALTH_W];
    assign w_h = r_rd_word[HEALTH_W-1:0];
    assign w_d = (w_t >= r_ts) ? (w_t - r_ts) : (r_ts - w_t);

    assign w_last_cnt = r_count - CNT_W'(1);
    assign w_last_idx = w_last_cnt[AW-1:0];

    // A capacity above the window depth acts as the depth itself.
    assign w_evict = (r_count != '0) &&
                     ((32'(r_count) >= 32'(i_cap)) || (32'(r_count) == 32'(WINDOW_DEPTH)));

    // Eviction moves the last slot into the oldest one, which may remove or
    // relocate the entry with an equal timestamp.
    assign w_eq_gone = w_evict && (r_eq_idx == r_min_idx);
    assign w_eqf = r_eq_found && !w_eq_gone;
    assign w_eq_pos = (w_evict && (r_eq_idx == w_last_idx)) ? r_min_idx : r_eq_idx;
    assign w_new_pos = w_eqf ? w_eq_pos : (w_evict ? w_last_idx : r_count[AW-1:0]);

    assign w_wr_en = (i_cmd.evict_wr && w_evict) || i_cmd.store_wr;
    assign w_wr_addr = i_cmd.evict_wr ? r_min_idx : w_new_pos;
    assign w_wr_data = i_cmd.evict_wr ? r_last_word : {r_ts, r_hv};

    assign w_matched = (r_count != '0) && (r_best_d < TIME_W'(i_mwin));

    assign o_sts.empty = (r_count == '0);
    assign o_sts.last_addr = (r_addr == w_last_idx);
    assign o_sts.is_query = (r_op == OP_QUERY);
    assign o_sts.out_busy = r_out_valid && !i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_healthy = r_out_healthy;
    assign o_matched = r_out_matched;
    assign o_degenerate = r_out_degenerate;
    assign o_was_degenerate = r_out_was_degenerate;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.scan) begin
            r_rd_word <= r_mem[r_addr];
            r_rd_idx <= r_addr;
        end
    end

    // Scan trackers and item payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_ts <= i_ts;
            r_hv <= i_hv;
        end
        if (r_rd_vld) begin
            if (!r_have || (w_t < r_min_t)) begin
                r_min_t <= w_t;
                r_min_idx <= r_rd_idx;
                r_min_h <= w_h;
            end
            // On an equal distance the entry below the query time wins.
            if (!r_have || (w_d < r_best_d) || ((w_d == r_best_d) && (w_t < r_best_t))) begin
                r_best_d <= w_d;
                r_best_t <= w_t;
                r_best_h <= w_h;
            end
            if (w_t == r_ts) begin
                r_eq_idx <= r_rd_idx;
                r_eq_h <= w_h;
            end
            if (r_rd_idx == w_last_idx) begin
                r_last_word <= r_rd_word;
            end
        end
        // The flags are captured with the answer, since the next item may
        // change them while this result still waits.
        if (i_cmd.result) begin
            r_out_matched <= (r_op == OP_QUERY) && w_matched;
            r_out_healthy <= (r_op == OP_QUERY) && w_matched && !r_flag && (r_best_h == '0);
            r_out_degenerate <= r_flag;
            r_out_was_degenerate <= r_prev_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_rd_vld <= 1'b0;
            r_have <= 1'b0;
            r_eq_found <= 1'b0;
            r_count <= '0;
            r_sum <= '0;
            r_flag <= 1'b0;
            r_prev_flag <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan;
            if (i_cmd.load) begin
                r_addr <= '0;
                r_have <= 1'b0;
                r_eq_found <= 1'b0;
            end else begin
                if (i_cmd.scan) begin
                    r_addr <= r_addr + AW'(1);
                end
                if (r_rd_vld) begin
                    r_have <= 1'b1;
                    if (w_t == r_ts) begin
                        r_eq_found <= 1'b1;
                    end
                end
            end
            if (i_cmd.store_wr) begin
                r_sum <= r_sum - SUM_W'(w_evict ? r_min_h : '0) - SUM_W'(w_eqf ? r_eq_h : '0)
                         + SUM_W'(r_hv);
                r_count <= r_count - CNT_W'(w_evict) + CNT_W'(!w_eqf);
            end
            if (i_cmd.flag_upd) begin
                r_prev_flag <= r_flag;
                if (r_flag) begin
                    if (r_sum == '0) begin
                        r_flag <= 1'b0;
                    end
                end else if (CMP_W'(r_sum) >= CMP_W'(i_thr)) begin
                    r_flag <= 1'b1;
                end
            end
            if (i_cmd.result) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

### design/health_window_degenerate_monitor.sv
`timescale 1ns / 1ps
// Each item first scans the window with one memory read per window entry; an
// empty window still passes through the scan state. A query result is then
// offered, while an add first evicts if needed, stores and updates the flag.
// Items are taken one at a time; the next transfer is accepted only after the
// result is loaded, later if the output register stalls.
// Reset (synchronous, active low) empties the window and clears both flags;
// the registers return to capacity 16, threshold 1 and match window 100 ms.
module health_window_degenerate_monitor import hwdm_pkg::*; #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input item
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [47:0]       i_s_tdata,   // [31:0] timestamp_ms, [47:32] health_value
    input  logic              i_s_tuser,   // [0] operation
    // Result item
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [7:0]        o_m_tdata,   // [0] healthy, [1] matched, [2] degenerate,
                                           // [3] was_degenerate, [7:4] zero
    // Configuration
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output logic [APB_DW-1:0] o_prdata,
    output logic              o_pready
);

    logic [CAP_W-1:0]  r_capacity;
    logic [THR_W-1:0]  r_threshold;
    logic [MWIN_W-1:0] r_match_win;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_healthy;
    logic w_matched;
    logic w_degenerate;
    logic w_was_degenerate;
    logic w_cfg_wr;
    logic [1:0] w_reg_idx;

    assign o_pready = 1'b1;
    assign w_cfg_wr = i_psel && i_penable && i_pwrite;
    assign w_reg_idx = i_paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RST;
            r_threshold <= THRESHOLD_RST;
            r_match_win <= MATCH_WIN_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_CAPACITY:  r_capacity <= i_pwdata[CAP_W-1:0];
                REG_THRESHOLD: r_threshold <= i_pwdata[THR_W-1:0];
                REG_MATCH_WIN: r_match_win <= i_pwdata[MWIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_CAPACITY:  o_prdata = APB_DW'(r_capacity);
            REG_THRESHOLD: o_prdata = APB_DW'(r_threshold);
            REG_MATCH_WIN: o_prdata = APB_DW'(r_match_win);
            default:       o_prdata = '0;
        endcase
    end

    hwdm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    hwdm_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_op             (i_s_tuser),
        .i_ts             (i_s_tdata[TIME_W-1:0]),
        .i_hv             (i_s_tdata[TIME_W+HEALTH_W-1:TIME_W]),
        .i_cap            (r_capacity),
        .i_thr            (r_threshold),
        .i_mwin           (r_match_win),
        .i_m_tready       (i_m_tready),
        .o_m_tvalid       (o_m_tvalid),
        .o_healthy        (w_healthy),
        .o_matched        (w_matched),
        .o_degenerate     (w_degenerate),
        .o_was_degenerate (w_was_degenerate)
    );

    assign o_m_tdata = {4'b0000, w_was_degenerate, w_degenerate, w_matched, w_healthy};

    // The two memory writes of an add never fall in the same cycle.
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.evict_wr && w_cmd.store_wr))
        else $error("eviction and store written in the same cycle");

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.result |-> !w_sts.out_busy)
        else $error("result loaded while the output is stalled");

    // A loaded result is offered in the next cycle.
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.result |=> o_m_tvalid)
        else $error("loaded result not offered");

    // No new item is taken while the previous one is still being processed.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken twice in a row");

endmodule

### dv/tb_health_window_degenerate_monitor.sv
`timescale 1ns / 1ps

module tb_health_window_degenerate_monitor;
    import hwdm_pkg::*;

    localparam int WINDOW_DEPTH = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES = 10;
    localparam int ITEMS_PER_PHASE = 188;

    typedef struct packed {
        logic was_degenerate;
        logic degenerate;
        logic matched;
        logic healthy;
    } t_verdict;

    // Tracks the time-ordered window and the hysteresis flag, and queues the verdict
    // that each accepted item must produce.
    class window_health_tracker;
        logic [TIME_W-1:0]   slot_time [WINDOW_DEPTH];
        logic [HEALTH_W-1:0] slot_health [WINDOW_DEPTH];
        int unsigned         fill;
        bit                  flag;
        bit                  prev_flag;
        logic [CAP_W-1:0]    cap;
        logic [THR_W-1:0]    thr;
        logic [MWIN_W-1:0]   mwin;
        t_verdict            expected_verdicts[$];
        int                  errors;
        int                  adds;
        int                  queries;
        int                  match_count;
        int                  healthy_answers;
        int                  flag_rises;

        function new();
            fill = 0;
            flag = 0;
            prev_flag = 0;
            cap = CAPACITY_RST;
            thr = THRESHOLD_RST;
            mwin = MATCH_WIN_RST;
            errors = 0;
            adds = 0;
            queries = 0;
            match_count = 0;
            healthy_answers = 0;
            flag_rises = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [APB_DW-1:0] val);
            case (idx)
                REG_CAPACITY:  cap = val[CAP_W-1:0];
                REG_THRESHOLD: thr = val[THR_W-1:0];
                REG_MATCH_WIN: mwin = val[MWIN_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction

        function void take_item(logic op, logic [TIME_W-1:0] ts, logic [HEALTH_W-1:0] hv);
            int unsigned       lim;
            int unsigned       pos;
            int unsigned       best;
            logic [TIME_W-1:0] d;
            logic [TIME_W-1:0] best_d;
            logic [31:0]       sum;
            t_verdict          v;
            v = '0;
            if (op == OP_ADD) begin
                adds++;
                lim = (cap > WINDOW_DEPTH) ? WINDOW_DEPTH : cap;
                if (fill >= lim && fill > 0) begin
                    for (int i = 1; i < fill; i++) begin
                        slot_time[i-1] = slot_time[i];
                        slot_health[i-1] = slot_health[i];
                    end
                    fill--;
                end
                pos = 0;
                while (pos < fill && slot_time[pos] < ts) pos++;
                if (pos < fill && slot_time[pos] == ts) begin
                    slot_health[pos] = hv;
                end else if (fill < WINDOW_DEPTH) begin
                    for (int i = fill; i > pos; i--) begin
                        slot_time[i] = slot_time[i-1];
                        slot_health[i] = slot_health[i-1];
                    end
                    slot_time[pos] = ts;
                    slot_health[pos] = hv;
                    fill++;
                end
                sum = '0;
                for (int i = 0; i < fill; i++) sum += slot_health[i];
                prev_flag = flag;
                if (flag) begin
                    if (sum == 0) flag = 0;
                end else if (sum >= thr) begin
                    flag = 1;
                    flag_rises++;
                end
            end else begin
                queries++;
                if (fill > 0) begin
                    best = 0;
                    best_d = '0;
                    // A strict comparison keeps the earlier entry on an equal distance.
                    for (int i = 0; i < fill; i++) begin
                        d = (slot_time[i] >= ts) ? slot_time[i] - ts : ts - slot_time[i];
                        if (i == 0 || d < best_d) begin
                            best = i;
                            best_d = d;
                        end
                    end
                    if (best_d < mwin) begin
                        v.matched = 1;
                        match_count++;
                        if (!flag && slot_health[best] == 0) begin
                            v.healthy = 1;
                            healthy_answers++;
                        end
                    end
                end
            end
            v.degenerate = flag;
            v.was_degenerate = prev_flag;
            expected_verdicts.push_back(v);
        endfunction

        function void check_verdict(logic [7:0] data);
            t_verdict e;
            t_verdict a;
            if (expected_verdicts.size() == 0) begin
                $error("result transfer with no verdict outstanding: tdata %h", data);
                errors++;
                return;
            end
            e = expected_verdicts.pop_front();
            a = data[3:0];
            if (a.healthy !== e.healthy) begin
                $error("healthy: expected %0b, got %0b", e.healthy, a.healthy);
                errors++;
            end
            if (a.matched !== e.matched) begin
                $error("matched: expected %0b, got %0b", e.matched, a.matched);
                errors++;
            end
            if (a.degenerate !== e.degenerate) begin
                $error("degenerate: expected %0b, got %0b", e.degenerate, a.degenerate);
                errors++;
            end
            if (a.was_degenerate !== e.was_degenerate) begin
                $error("was_degenerate: expected %0b, got %0b",
                       e.was_degenerate, a.was_degenerate);
                errors++;
            end
            if (data[7:4] !== 4'b0) begin
                $error("padding: expected 0, got %h", data[7:4]);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [47:0]       i_s_tdata = '0;   // [31:0] timestamp_ms, [47:32] health_value
    logic              i_s_tuser = 1'b0; // [0] operation
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [7:0]        o_m_tdata;        // [0] healthy, [1] matched, [2] degenerate,
                                         // [3] was_degenerate, [7:4] zero
    logic              i_psel = 1'b0;
    logic              i_penable = 1'b0;
    logic              i_pwrite = 1'b0;
    logic [APB_AW-1:0] i_paddr = '0;
    logic [APB_DW-1:0] i_pwdata = '0;
    logic [APB_DW-1:0] o_prdata;
    logic              o_pready;

    window_health_tracker tracker = new();

    bit                stall_on = 1'b0;
    int                rx_hold = 0;
    int                cycle_count = 0;
    logic [TIME_W-1:0] now_ms = '0;
    logic [TIME_W-1:0] last_add_ms = '0;

    health_window_degenerate_monitor #(.WINDOW_DEPTH(WINDOW_DEPTH)) dut (.*);

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: tready is dropped in random bursts while stalls are on.
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            i_m_tready <= 1'b0;
        end else if (stall_on && $urandom_range(0, 7) == 0) begin
            rx_hold <= $urandom_range(0, 11);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                tracker.take_item(i_s_tuser, i_s_tdata[31:0], i_s_tdata[47:32]);
            if (o_m_tvalid && i_m_tready)
                tracker.check_verdict(o_m_tdata);
        end
    end

    task automatic send_item(logic op, logic [TIME_W-1:0] ts, logic [HEALTH_W-1:0] hv);
        if (stall_on && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= op;
        i_s_tdata <= {hv, ts};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [APB_DW-1:0] val);
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= {idx, 2'b00};
        i_pwdata <= val;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
        tracker.set_register(idx, val);
        @(posedge i_clk);
    endtask

    // Drops tvalid and waits until no verdict is outstanding before returning.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (WINDOW_DEPTH + 10) @(posedge i_clk);
    endtask

    task automatic random_item(logic [MWIN_W-1:0] mwin);
        logic              op;
        logic [TIME_W-1:0] ts;
        logic [HEALTH_W-1:0] hv;
        int unsigned       off;
        int unsigned       pick;
        pick = $urandom_range(0, 99);
        hv = HEALTH_W'($urandom);
        if (pick < 55) begin
            op = OP_ADD;
            now_ms = now_ms + $urandom_range(0, 40);
            if (pick < 6)
                ts = last_add_ms;
            else if (pick < 9)
                ts = $urandom;
            else
                ts = now_ms;
            pick = $urandom_range(0, 99);
            if (pick < 78)
                hv = '0;
            else if (pick < 90)
                hv = HEALTH_W'($urandom_range(1, 3));
            last_add_ms = ts;
        end else begin
            op = OP_QUERY;
            if (pick < 60) begin
                ts = $urandom;
            end else begin
                // Aim some queries exactly at the edge of the match window.
                if (pick < 68)
                    off = mwin - (pick & 1);
                else
                    off = $urandom_range(0, (mwin > 300) ? 300 : mwin + 3);
                ts = $urandom_range(0, 1) ? last_add_ms + off : last_add_ms - off;
            end
        end
        send_item(op, ts, hv);
    endtask

    initial begin
        int unsigned cap_set [PHASES];
        int unsigned thr_set [PHASES];
        int unsigned mwin_set [PHASES];
        cap_set = '{16, 4, 31, 1, 0, 8, 3, 16, 17, 5};
        thr_set = '{1, 0, 1048575, 3, 100000, 2, 1, 65536, 0, 4};
        mwin_set = '{100, 0, 65535, 20, 1, 300, 100, 65535, 50, 7};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: empty window, match window bounds, replacement and the flag.
        send_item(OP_QUERY, 32'd0, 16'hFFFF);
        send_item(OP_ADD, 32'd1000, 16'd0);
        send_item(OP_QUERY, 32'd1000, 16'd0);
        send_item(OP_QUERY, 32'd1099, 16'd0);
        send_item(OP_QUERY, 32'd1100, 16'd0);
        send_item(OP_QUERY, 32'd901, 16'd0);
        send_item(OP_ADD, 32'd1000, 16'd5);
        send_item(OP_QUERY, 32'd1000, 16'd0);
        send_item(OP_ADD, 32'd1000, 16'd0);
        send_item(OP_ADD, 32'd0, 16'hFFFF);
        send_item(OP_ADD, 32'd0, 16'd0);
        send_item(OP_QUERY, 32'hFFFF_FFFF, 16'd0);
        wait_idle();

        // Small window with a high threshold so the flag stays clear.
        write_reg(REG_CAPACITY, 32'd2);
        write_reg(REG_THRESHOLD, 32'd1048575);
        write_reg(REG_MATCH_WIN, 32'd65535);
        send_item(OP_ADD, 32'd2000, 16'd0);
        send_item(OP_ADD, 32'd2100, 16'd7);
        send_item(OP_QUERY, 32'd2050, 16'd0);
        send_item(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(OP_QUERY, 32'd2050, 16'd0);
        send_item(OP_QUERY, 32'hFFFF_FFFF, 16'd0);
        send_item(OP_ADD, 32'd2100, 16'd0);
        send_item(OP_QUERY, 32'd2100, 16'd0);
        wait_idle();

        // A capacity of zero keeps only the newest entry.
        write_reg(REG_CAPACITY, 32'd0);
        send_item(OP_ADD, 32'd5, 16'd1);
        send_item(OP_ADD, 32'd6, 16'd0);
        send_item(OP_QUERY, 32'd5, 16'd0);
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            write_reg(REG_CAPACITY, cap_set[p]);
            write_reg(REG_THRESHOLD, thr_set[p]);
            write_reg(REG_MATCH_WIN, mwin_set[p]);
            stall_on = (p < 8) && (p != 2);
            now_ms = (p == 5) ? 32'hFFFF_F000 : $urandom;
            last_add_ms = now_ms;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                random_item(mwin_set[p]);
            wait_idle();
        end

        $display("Sent %0d adds and %0d queries over %0d register settings.",
                 tracker.adds, tracker.queries, PHASES + 3);
        $display("%0d queries matched, %0d answered healthy; the flag rose %0d times.",
                 tracker.match_count, tracker.healthy_answers, tracker.flag_rises);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
design/hwdm_pkg.sv
design/hwdm_ctrl.sv
design/hwdm_dp.sv
design/health_window_degenerate_monitor.sv
dv/tb_health_window_degenerate_monitor.sv
